/* hw/rtl/jbt_pkg.sv */
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared types and constants of the JSON byte tokenizer: event kinds, error
// codes, the result record and the queue geometry.
// ----------------------------------------------------------------------------
package jbt_pkg;

	// Event kinds carried on the token channel.
	localparam logic [3:0] EV_LBRACE  = 4'd0;
	localparam logic [3:0] EV_RBRACE  = 4'd1;
	localparam logic [3:0] EV_LBRACK  = 4'd2;
	localparam logic [3:0] EV_RBRACK  = 4'd3;
	localparam logic [3:0] EV_COMMA   = 4'd4;
	localparam logic [3:0] EV_COLON   = 4'd5;
	localparam logic [3:0] EV_STRBYTE = 4'd6;
	localparam logic [3:0] EV_STREND  = 4'd7;
	localparam logic [3:0] EV_NUMBYTE = 4'd8;
	localparam logic [3:0] EV_NUMEND  = 4'd9;
	localparam logic [3:0] EV_NULL    = 4'd10;
	localparam logic [3:0] EV_TRUE    = 4'd11;
	localparam logic [3:0] EV_FALSE   = 4'd12;
	localparam logic [3:0] EV_EOS     = 4'd13;
	localparam logic [3:0] EV_ERROR   = 4'd14;

	// Error codes.
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_LITERAL   = 3'd1;
	localparam logic [2:0] ERR_HEX       = 3'd2;
	localparam logic [2:0] ERR_ESCAPE    = 3'd3;
	localparam logic [2:0] ERR_UNTERM    = 3'd4;

	// At most this many events leave for one input byte.
	localparam int MAX_RES = 3;

	// Result queue geometry.
	localparam int Q_DEPTH = 8;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);
	// A byte may enter only if two bursts still fit behind the queued events.
	localparam int Q_READY_MAX = Q_DEPTH - 2 * MAX_RES;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] value;
		logic [2:0] err;
		logic       last;
	} res_t;

	// Events produced by the lexer in one cycle, oldest in entry 0.
	typedef struct packed {
		res_t [MAX_RES-1:0] res;
		logic [1:0]         count;
	} push_t;

	typedef struct packed {
		logic idle;
		logic err;
	} status_t;

endpackage

/* hw/rtl/jbt_if.sv */
// ----------------------------------------------------------------------------
// jbt_byte_if / jbt_token_if
// Valid/ready channels of the tokenizer: input bytes and token events.
// ----------------------------------------------------------------------------
interface jbt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface jbt_token_if;
	logic       valid;
	logic       ready;
	logic [3:0] event_kind;
	logic [7:0] value_byte;
	logic [2:0] error_code;
	logic       last_of_run;

	modport source (output valid, output event_kind, output value_byte,
		output error_code, output last_of_run, input ready);
	modport sink   (input valid, input event_kind, input value_byte,
		input error_code, input last_of_run, output ready);
endinterface

/* hw/rtl/jbt_lexer.sv */
// ----------------------------------------------------------------------------
// jbt_lexer
// Lexer state and the combinational decode of one byte into zero to three
// token events.
// ----------------------------------------------------------------------------
module jbt_lexer
	import jbt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  logic [7:0] data_byte,
	input  logic       end_of_input,
	output push_t      push,
	output status_t    status
);

	typedef enum logic [7:0] {
		M_IDLE    = 8'b0000_0001,
		M_SLASH   = 8'b0000_0010,
		M_COMMENT = 8'b0000_0100,
		M_LITERAL = 8'b0000_1000,
		M_STRING  = 8'b0001_0000,
		M_ESCAPE  = 8'b0010_0000,
		M_UNICODE = 8'b0100_0000,
		M_NUMBER  = 8'b1000_0000
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [1:0]  lit_sel_q, lit_sel_d;
	logic [2:0]  lit_pos_q, lit_pos_d;
	logic [15:0] cp_q, cp_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [2:0]  phase_q, phase_d;
	logic        err_q, err_d;

	res_t [MAX_RES-1:0] res;
	logic [1:0]         n;

	function automatic res_t mk(input logic [3:0] kind, input logic [7:0] value,
		input logic [2:0] err);
		return '{kind: kind, value: value, err: err, last: 1'b0};
	endfunction

	// Expected byte of a literal after its first letter.
	function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		case (sel)
			2'd0: case (pos[1:0])
				2'd0: ch = "u";
				2'd1: ch = "l";
				2'd2: ch = "l";
				default: ch = 8'h00;
			endcase
			2'd1: case (pos[1:0])
				2'd0: ch = "r";
				2'd1: ch = "u";
				2'd2: ch = "e";
				default: ch = 8'h00;
			endcase
			default: case (pos[1:0])
				2'd0: ch = "a";
				2'd1: ch = "l";
				2'd2: ch = "s";
				default: ch = "e";
			endcase
		endcase
		return ch;
	endfunction

	// Returns {is_hex, value}.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= "0" && c <= "9")
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= "a" && c <= "f")
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= "A" && c <= "F")
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	always_comb begin
		logic       do_num;
		logic       do_idle;
		logic       dig;
		logic       ex;
		logic       acc;
		logic [2:0] ph;
		logic [4:0] hx;
		logic [1:0] sel;
		logic [2:0] len;
		logic [15:0] cp;
		logic [7:0] c;

		c         = data_byte;
		mode_d    = mode_q;
		lit_sel_d = lit_sel_q;
		lit_pos_d = lit_pos_q;
		cp_d      = cp_q;
		hex_cnt_d = hex_cnt_q;
		phase_d   = phase_q;
		err_d     = err_q;
		res       = '0;
		n         = 2'd0;
		do_num    = 1'b0;
		do_idle   = 1'b0;
		ph        = phase_q;
		acc       = 1'b0;
		dig       = (c >= "0" && c <= "9");
		ex        = (c == "e" || c == "E");
		hx        = hex_val(c);
		sel       = (lit_sel_q > 2'd2) ? 2'd0 : lit_sel_q;
		len       = (sel == 2'd2) ? 3'd4 : 3'd3;
		cp        = {cp_q[11:0], hx[3:0]};

		if (end_of_input) begin
			if (!err_q) begin
				unique case (mode_q)
					M_SLASH: begin
						res[n] = mk(EV_NUMBYTE, "/", ERR_NONE); n = n + 2'd1;
						res[n] = mk(EV_NUMEND, 8'h00, ERR_NONE); n = n + 2'd1;
					end
					M_NUMBER: begin
						res[n] = mk(EV_NUMEND, 8'h00, ERR_NONE); n = n + 2'd1;
					end
					M_LITERAL: begin
						res[n] = mk(EV_ERROR, 8'h00, ERR_LITERAL); n = n + 2'd1;
					end
					M_STRING, M_UNICODE: begin
						res[n] = mk(EV_ERROR, 8'h00, ERR_UNTERM); n = n + 2'd1;
					end
					M_ESCAPE: begin
						res[n] = mk(EV_ERROR, 8'h00, ERR_ESCAPE); n = n + 2'd1;
					end
					default: ;
				endcase
			end
			res[n] = mk(EV_EOS, 8'h00, ERR_NONE); n = n + 2'd1;
			mode_d    = M_IDLE;
			lit_sel_d = '0;
			lit_pos_d = '0;
			cp_d      = '0;
			hex_cnt_d = '0;
			phase_d   = '0;
			err_d     = 1'b0;
		end else if (!err_q) begin
			unique case (mode_q)
				M_SLASH: begin
					if (c == "/") begin
						mode_d = M_COMMENT;
					end else begin
						// A lone slash opens a number that starts with the slash.
						res[n] = mk(EV_NUMBYTE, "/", ERR_NONE); n = n + 2'd1;
						ph     = 3'd0;
						do_num = 1'b1;
					end
				end
				M_COMMENT: begin
					if (c == 8'h0A)
						mode_d = M_IDLE;
				end
				M_LITERAL: begin
					if (lit_pos_q >= len || c != lit_char(sel, lit_pos_q)) begin
						res[n] = mk(EV_ERROR, 8'h00, ERR_LITERAL); n = n + 2'd1;
						err_d  = 1'b1;
						mode_d = M_IDLE;
					end else if (lit_pos_q + 3'd1 == len) begin
						res[n] = mk(EV_NULL + {2'b00, sel}, 8'h00, ERR_NONE); n = n + 2'd1;
						mode_d    = M_IDLE;
						lit_pos_d = 3'd0;
					end else begin
						lit_pos_d = lit_pos_q + 3'd1;
					end
				end
				M_STRING: begin
					if (c == 8'h22) begin
						res[n] = mk(EV_STREND, 8'h00, ERR_NONE); n = n + 2'd1;
						mode_d = M_IDLE;
					end else if (c == 8'h5C) begin
						mode_d = M_ESCAPE;
					end else begin
						res[n] = mk(EV_STRBYTE, c, ERR_NONE); n = n + 2'd1;
					end
				end
				M_ESCAPE: begin
					case (c)
						8'h22, "/", 8'h5C: begin
							res[n] = mk(EV_STRBYTE, c, ERR_NONE); n = n + 2'd1;
							mode_d = M_STRING;
						end
						"b": begin
							res[n] = mk(EV_STRBYTE, 8'h08, ERR_NONE); n = n + 2'd1;
							mode_d = M_STRING;
						end
						"f": begin
							res[n] = mk(EV_STRBYTE, 8'h0C, ERR_NONE); n = n + 2'd1;
							mode_d = M_STRING;
						end
						"n": begin
							res[n] = mk(EV_STRBYTE, 8'h0A, ERR_NONE); n = n + 2'd1;
							mode_d = M_STRING;
						end
						"r": begin
							res[n] = mk(EV_STRBYTE, 8'h0D, ERR_NONE); n = n + 2'd1;
							mode_d = M_STRING;
						end
						"t": begin
							res[n] = mk(EV_STRBYTE, 8'h09, ERR_NONE); n = n + 2'd1;
							mode_d = M_STRING;
						end
						"u": begin
							mode_d    = M_UNICODE;
							cp_d      = '0;
							hex_cnt_d = '0;
						end
						default: begin
							res[n] = mk(EV_ERROR, 8'h00, ERR_ESCAPE); n = n + 2'd1;
							err_d  = 1'b1;
							mode_d = M_IDLE;
						end
					endcase
				end
				M_UNICODE: begin
					if (!hx[4]) begin
						res[n] = mk(EV_ERROR, 8'h00, ERR_HEX); n = n + 2'd1;
						err_d  = 1'b1;
						mode_d = M_IDLE;
					end else begin
						cp_d = cp;
						if (hex_cnt_q == 2'd3) begin
							// Fourth digit: emit the code point as UTF-8.
							if (cp <= 16'h007F) begin
								res[n] = mk(EV_STRBYTE, cp[7:0], ERR_NONE); n = n + 2'd1;
							end else if (cp <= 16'h07FF) begin
								res[n] = mk(EV_STRBYTE, {3'b110, cp[10:6]}, ERR_NONE);
								n = n + 2'd1;
								res[n] = mk(EV_STRBYTE, {2'b10, cp[5:0]}, ERR_NONE);
								n = n + 2'd1;
							end else begin
								res[n] = mk(EV_STRBYTE, {4'b1110, cp[15:12]}, ERR_NONE);
								n = n + 2'd1;
								res[n] = mk(EV_STRBYTE, {2'b10, cp[11:6]}, ERR_NONE);
								n = n + 2'd1;
								res[n] = mk(EV_STRBYTE, {2'b10, cp[5:0]}, ERR_NONE);
								n = n + 2'd1;
							end
							hex_cnt_d = 2'd0;
							mode_d    = M_STRING;
						end else begin
							hex_cnt_d = hex_cnt_q + 2'd1;
						end
					end
				end
				M_NUMBER: begin
					do_num = 1'b1;
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase

			if (do_num) begin
				phase_d = ph;
				case (ph)
					3'd0: begin
						if (c == "-" || dig) begin
							acc = 1'b1; phase_d = 3'd1;
						end else if (c == ".") begin
							acc = 1'b1; phase_d = 3'd2;
						end else if (ex) begin
							acc = 1'b1; phase_d = 3'd3;
						end
					end
					3'd1: begin
						if (dig) begin
							acc = 1'b1;
						end else if (c == ".") begin
							acc = 1'b1; phase_d = 3'd2;
						end else if (ex) begin
							acc = 1'b1; phase_d = 3'd3;
						end
					end
					3'd2: begin
						if (dig) begin
							acc = 1'b1;
						end else if (ex) begin
							acc = 1'b1; phase_d = 3'd3;
						end
					end
					3'd3: begin
						if (c == "+" || c == "-" || dig) begin
							acc = 1'b1; phase_d = 3'd4;
						end
					end
					3'd4: acc = dig;
					default: acc = 1'b0;
				endcase
				if (acc) begin
					res[n] = mk(EV_NUMBYTE, c, ERR_NONE); n = n + 2'd1;
					mode_d = M_NUMBER;
				end else begin
					res[n] = mk(EV_NUMEND, 8'h00, ERR_NONE); n = n + 2'd1;
					do_idle = 1'b1;
				end
			end

			if (do_idle) begin
				mode_d = M_IDLE;
				if (!((c >= 8'h09 && c <= 8'h0D) || c == 8'h20)) begin
					case (c)
						"{": begin res[n] = mk(EV_LBRACE, 8'h00, ERR_NONE); n = n + 2'd1; end
						"}": begin res[n] = mk(EV_RBRACE, 8'h00, ERR_NONE); n = n + 2'd1; end
						"[": begin res[n] = mk(EV_LBRACK, 8'h00, ERR_NONE); n = n + 2'd1; end
						"]": begin res[n] = mk(EV_RBRACK, 8'h00, ERR_NONE); n = n + 2'd1; end
						",": begin res[n] = mk(EV_COMMA, 8'h00, ERR_NONE); n = n + 2'd1; end
						":": begin res[n] = mk(EV_COLON, 8'h00, ERR_NONE); n = n + 2'd1; end
						"n": begin mode_d = M_LITERAL; lit_sel_d = 2'd0; lit_pos_d = 3'd0; end
						"t": begin mode_d = M_LITERAL; lit_sel_d = 2'd1; lit_pos_d = 3'd0; end
						"f": begin mode_d = M_LITERAL; lit_sel_d = 2'd2; lit_pos_d = 3'd0; end
						8'h22: mode_d = M_STRING;
						"/": mode_d = M_SLASH;
						default: begin
							res[n] = mk(EV_NUMBYTE, c, ERR_NONE); n = n + 2'd1;
							mode_d  = M_NUMBER;
							phase_d = 3'd0;
						end
					endcase
				end
			end
		end

		for (int i = 0; i < MAX_RES; i++)
			res[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_IDLE;
			lit_sel_q <= '0;
			lit_pos_q <= '0;
			cp_q      <= '0;
			hex_cnt_q <= '0;
			phase_q   <= '0;
			err_q     <= 1'b0;
		end else if (valid) begin
			mode_q    <= mode_d;
			lit_sel_q <= lit_sel_d;
			lit_pos_q <= lit_pos_d;
			cp_q      <= cp_d;
			hex_cnt_q <= hex_cnt_d;
			phase_q   <= phase_d;
			err_q     <= err_d;
		end
	end

	assign push.res   = res;
	assign push.count = valid ? n : 2'd0;

	assign status.idle = (mode_q == M_IDLE);
	assign status.err  = err_q;

endmodule

/* hw/rtl/jbt_queue.sv */
// ----------------------------------------------------------------------------
// jbt_queue
// Result queue that takes up to three events per cycle and hands out one.
// ----------------------------------------------------------------------------
module jbt_queue
	import jbt_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  push_t           push,
	input  logic            pop,
	output res_t            head,
	output logic [Q_CW-1:0] count
);

	res_t            mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push.count)
				mem[wr_ptr_q + Q_AW'(i)] <= push.res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_AW'(push.count);
			rd_ptr_q <= rd_ptr_q + Q_AW'(pop);
			count_q  <= count_q + Q_CW'(push.count) - Q_CW'(pop);
		end
	end

	assign head  = mem[rd_ptr_q];
	assign count = count_q;

endmodule

/* hw/rtl/json_byte_tokenizer.sv */
// ----------------------------------------------------------------------------
// json_byte_tokenizer
// JSON lexer: one input byte per transaction, token events out.
// ----------------------------------------------------------------------------
// Usage: bytes carries one JSON character per transaction, or an end-of-input
// marker. tokens carries one event per transaction; the events caused by one
// byte leave in order and the final one has last_of_run set. Whitespace,
// line comments and the openings of strings and literals cause no event.
// A byte is registered when it is taken, decoded in the next cycle and its
// zero to three events are written into an eight-entry queue; the first
// event can be taken once it is in the queue. The block takes one byte
// every cycle while the queue holds at most two events; the queue depth and
// the three-event worst case per byte set that bound. With the receiver
// always ready and at most one event per byte on average, the rate is one
// byte per cycle. When the receiver stalls, events wait in the queue and
// bytes keep flowing until it fills past that mark, then ready drops.
// After a lexical error the block emits one error event and ignores bytes
// until end of input, which always produces an end-of-stream event and
// returns the lexer to idle. Reset empties the queue and the input stage and
// puts the lexer in idle with no error.
// ----------------------------------------------------------------------------
module json_byte_tokenizer
	import jbt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	jbt_byte_if.sink    bytes,
	jbt_token_if.source tokens
);

	// Input stage: the accepted byte is held here while the lexer decodes it.
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eoi_s1;

	push_t            lex_push;
	status_t          lex_status;
	res_t             head;
	logic [Q_CW-1:0]  q_count;
	logic             take_in;
	logic             pop;

	// Worst case, the byte in the input stage and the one taken now both
	// produce three events before anything leaves.
	assign bytes.ready = (q_count <= Q_CW'(Q_READY_MAX));
	assign take_in     = bytes.valid && bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= take_in;
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			data_s1 <= bytes.data_byte;
			eoi_s1  <= bytes.end_of_input;
		end
	end

	jbt_lexer u_lexer (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (valid_s1),
		.data_byte    (data_s1),
		.end_of_input (eoi_s1),
		.push         (lex_push),
		.status       (lex_status)
	);

	// The queue parts the decode from the receiver; its head is the output.
	jbt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (lex_push),
		.pop    (pop),
		.head   (head),
		.count  (q_count)
	);

	assign tokens.valid       = (q_count != '0);
	assign pop                = tokens.valid && tokens.ready;
	assign tokens.event_kind  = head.kind;
	assign tokens.value_byte  = head.value;
	assign tokens.error_code  = head.err;
	assign tokens.last_of_run = head.last;

	// The ready threshold must keep the queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= Q_CW'(Q_DEPTH))
		else $error("result queue overflow");

	// End of input always produces at least the end-of-stream event.
	a_eoi_emits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && eoi_s1 |-> lex_push.count != 2'd0)
		else $error("end of input produced no event");

	// End of input leaves the lexer idle with the error cleared.
	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && eoi_s1 |=> lex_status.idle && !lex_status.err)
		else $error("lexer not idle after end of input");

	// A latched error silences ordinary bytes.
	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !eoi_s1 && lex_status.err |-> lex_push.count == 2'd0)
		else $error("event emitted while an error is latched");

endmodule

/* tb/json_byte_tokenizer_tb.sv */
// ----------------------------------------------------------------------------
// json_byte_tokenizer_tb
// Self-checking bench for the JSON byte tokenizer. A short table of directed
// bytes is followed by randomly built JSON-like token streams. The expected
// events come from typed table rows or else from a behavioral lexer in the
// bench. Each event taken from the block is checked in order, field by field.
// ----------------------------------------------------------------------------
module json_byte_tokenizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import jbt_pkg::*;

	// Cycles without any transaction on either channel before the run is
	// declared hung. The longest legal quiet stretch is the receiver hold-off.
	localparam int WATCHDOG_LIMIT = 4000;
	// A byte passes the block's input stage and its queue before its first event can be taken.
	localparam int DRAIN_CYCLES   = 12;
	localparam int HOLD_CYCLES    = 400;
	localparam int PHASE_ITEMS    = 140;
	localparam int DIR_ROWS       = 26;
	localparam int MAX_REPORTS    = 10;

	localparam res_t NO_RES = '0;

	// Modes of the bench's own lexer.
	typedef enum logic [3:0] {
		LX_IDLE, LX_SLASH, LX_COMMENT, LX_LITERAL,
		LX_STRING, LX_ESCAPE, LX_UNICODE, LX_NUMBER
	} lex_mode_e;

	// Progress through the number pattern.
	typedef enum logic [2:0] {
		NP_START, NP_INT, NP_FRAC, NP_EXP, NP_EXPDIG
	} num_phase_e;

	typedef enum logic [1:0] {
		LIT_NULL, LIT_TRUE, LIT_FALSE
	} lit_sel_e;

	// One byte transaction. When typed is set, the events in rs are the
	// expectation for this byte as written in the directed table; otherwise
	// the bench lexer supplies them.
	typedef struct packed {
		logic [7:0]       data;
		logic             eoi;
		logic             typed;
		logic [1:0]       cnt;
		res_t [MAX_RES-1:0] rs;
	} stim_t;

	logic clk;
	logic arst_n;

	jbt_byte_if  byte_ch();
	jbt_token_if token_ch();

	json_byte_tokenizer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.tokens (token_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Bench lexer state. It mirrors the block's lexer state one for one and
	// is advanced once per accepted byte transaction.
	// ------------------------------------------------------------------------
	lex_mode_e   lx_mode;
	lit_sel_e    lit_sel;
	logic [2:0]  lit_pos;
	logic [15:0] cp_accum;
	logic [1:0]  hex_cnt;
	num_phase_e  num_phase;
	logic        halted;

	// Events caused by the byte being predicted, oldest first.
	res_t burst[$];
	// Events still owed by the block, oldest first.
	res_t tok_expect[$];
	// Byte transactions on offer or waiting to be matched with acceptance.
	stim_t offered[$];
	// Random stream of the current phase.
	stim_t plan[$];

	int src_idle_pct = 34;
	int snk_idle_pct = 56;
	int hold_len     = 0;
	bit hold_go      = 1'b0;
	bit hold_seen;
	int hold_cnt;

	int mismatches = 0;
	int n_bytes    = 0;
	int n_events   = 0;
	int n_errs     = 0;
	int n_eos      = 0;
	int n_bursts3  = 0;

	// Values sampled at the falling edge, after the block and the bench last
	// changed anything; used at the following rising edge.
	bit   byte_fire = 1'b0;
	bit   tok_fire  = 1'b0;
	res_t tok_got;

	function automatic res_t tk(logic [3:0] k, logic [7:0] v, logic [2:0] e, logic l);
		res_t r;
		r.kind  = k;
		r.value = v;
		r.err   = e;
		r.last  = l;
		return r;
	endfunction

	function automatic stim_t mk(logic [7:0] d, logic e, logic typed, logic [1:0] cnt,
			res_t r0, res_t r1, res_t r2);
		stim_t s;
		s.data  = d;
		s.eoi   = e;
		s.typed = typed;
		s.cnt   = cnt;
		s.rs[0] = r0;
		s.rs[1] = r1;
		s.rs[2] = r2;
		return s;
	endfunction

	function automatic stim_t raw(logic [7:0] d, logic e);
		return mk(d, e, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES);
	endfunction

	// ------------------------------------------------------------------------
	// Bench lexer.
	// ------------------------------------------------------------------------
	function automatic void put_event(logic [3:0] k, logic [7:0] v, logic [2:0] e);
		if (burst.size() < MAX_RES)
			burst.push_back(tk(k, v, e, 1'b0));
	endfunction

	// An error is reported once; the lexer then ignores bytes until the end
	// of input.
	function automatic void flag_error(logic [2:0] code);
		put_event(EV_ERROR, 8'h00, code);
		halted  = 1'b1;
		lx_mode = LX_IDLE;
	endfunction

	function automatic int hex_nibble(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	function automatic int lit_length(lit_sel_e sel);
		return (sel == LIT_FALSE) ? 4 : 3;
	endfunction

	// Character of a literal after its first byte, counted from zero.
	function automatic logic [7:0] lit_char(lit_sel_e sel, int pos);
		logic [31:0] txt;
		int len;
		len = lit_length(sel);
		case (sel)
			LIT_TRUE:  txt = "rue";
			LIT_FALSE: txt = "alse";
			default:   txt = "ull";
		endcase
		return txt[8*(len-1-pos) +: 8];
	endfunction

	// Steps the number pattern; returns 1 when c still belongs to the number.
	function automatic bit num_continues(logic [7:0] c);
		bit dig;
		bit ex;
		dig = (c >= "0" && c <= "9");
		ex  = (c == "e" || c == "E");
		case (num_phase)
			NP_START: begin
				if (c == "-" || dig) begin num_phase = NP_INT; return 1'b1; end
				if (c == ".") begin num_phase = NP_FRAC; return 1'b1; end
				if (ex) begin num_phase = NP_EXP; return 1'b1; end
				return 1'b0;
			end
			NP_INT: begin
				if (dig) return 1'b1;
				if (c == ".") begin num_phase = NP_FRAC; return 1'b1; end
				if (ex) begin num_phase = NP_EXP; return 1'b1; end
				return 1'b0;
			end
			NP_FRAC: begin
				if (dig) return 1'b1;
				if (ex) begin num_phase = NP_EXP; return 1'b1; end
				return 1'b0;
			end
			NP_EXP: begin
				if (c == "+" || c == "-" || dig) begin
					num_phase = NP_EXPDIG;
					return 1'b1;
				end
				return 1'b0;
			end
			NP_EXPDIG: return dig;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic void open_literal(lit_sel_e sel);
		lx_mode = LX_LITERAL;
		lit_sel = sel;
		lit_pos = 3'd0;
	endfunction

	function automatic void lex_idle(logic [7:0] c);
		lx_mode = LX_IDLE;
		if ((c >= 8'd9 && c <= 8'd13) || c == " ") return;
		case (c)
			"{":  put_event(EV_LBRACE, 8'h00, ERR_NONE);
			"}":  put_event(EV_RBRACE, 8'h00, ERR_NONE);
			"[":  put_event(EV_LBRACK, 8'h00, ERR_NONE);
			"]":  put_event(EV_RBRACK, 8'h00, ERR_NONE);
			",":  put_event(EV_COMMA, 8'h00, ERR_NONE);
			":":  put_event(EV_COLON, 8'h00, ERR_NONE);
			"n":  open_literal(LIT_NULL);
			"t":  open_literal(LIT_TRUE);
			"f":  open_literal(LIT_FALSE);
			"\"": lx_mode = LX_STRING;
			"/":  lx_mode = LX_SLASH;
			default: begin
				put_event(EV_NUMBYTE, c, ERR_NONE);
				lx_mode   = LX_NUMBER;
				num_phase = NP_START;
			end
		endcase
	endfunction

	function automatic void lex_number(logic [7:0] c);
		if (num_continues(c)) begin
			put_event(EV_NUMBYTE, c, ERR_NONE);
		end else begin
			put_event(EV_NUMEND, 8'h00, ERR_NONE);
			lex_idle(c);
		end
	endfunction

	function automatic void put_utf8(logic [15:0] cp);
		if (cp <= 16'h007F) begin
			put_event(EV_STRBYTE, cp[7:0], ERR_NONE);
		end else if (cp <= 16'h07FF) begin
			put_event(EV_STRBYTE, {3'b110, cp[10:6]}, ERR_NONE);
			put_event(EV_STRBYTE, {2'b10, cp[5:0]}, ERR_NONE);
		end else begin
			put_event(EV_STRBYTE, {4'b1110, cp[15:12]}, ERR_NONE);
			put_event(EV_STRBYTE, {2'b10, cp[11:6]}, ERR_NONE);
			put_event(EV_STRBYTE, {2'b10, cp[5:0]}, ERR_NONE);
		end
	endfunction

	function automatic void lex_escape(logic [7:0] c);
		logic [7:0] v;
		case (c)
			"\"", "/", "\\": v = c;
			"b": v = 8'd8;
			"f": v = 8'd12;
			"n": v = 8'd10;
			"r": v = 8'd13;
			"t": v = 8'd9;
			"u": begin
				lx_mode  = LX_UNICODE;
				cp_accum = 16'h0000;
				hex_cnt  = 2'd0;
				return;
			end
			default: begin
				flag_error(ERR_ESCAPE);
				return;
			end
		endcase
		put_event(EV_STRBYTE, v, ERR_NONE);
		lx_mode = LX_STRING;
	endfunction

	function automatic void lex_literal(logic [7:0] c);
		int len;
		len = lit_length(lit_sel);
		if (int'(lit_pos) >= len || c != lit_char(lit_sel, int'(lit_pos))) begin
			flag_error(ERR_LITERAL);
			return;
		end
		if (int'(lit_pos) + 1 == len) begin
			case (lit_sel)
				LIT_TRUE:  put_event(EV_TRUE, 8'h00, ERR_NONE);
				LIT_FALSE: put_event(EV_FALSE, 8'h00, ERR_NONE);
				default:   put_event(EV_NULL, 8'h00, ERR_NONE);
			endcase
			lx_mode = LX_IDLE;
			lit_pos = 3'd0;
		end else begin
			lit_pos = lit_pos + 3'd1;
		end
	endfunction

	function automatic void lex_unicode(logic [7:0] c);
		int h;
		h = hex_nibble(c);
		if (h < 0) begin
			flag_error(ERR_HEX);
			return;
		end
		cp_accum = {cp_accum[11:0], 4'(h)};
		if (hex_cnt == 2'd3) begin
			put_utf8(cp_accum);
			hex_cnt = 2'd0;
			lx_mode = LX_STRING;
		end else begin
			hex_cnt = hex_cnt + 2'd1;
		end
	endfunction

	function automatic void lex_reset();
		lx_mode   = LX_IDLE;
		lit_sel   = LIT_NULL;
		lit_pos   = 3'd0;
		cp_accum  = 16'h0000;
		hex_cnt   = 2'd0;
		num_phase = NP_START;
		halted    = 1'b0;
	endfunction

	// End of input closes whatever token is open, then always gives eos.
	function automatic void lex_end();
		if (!halted) begin
			case (lx_mode)
				LX_SLASH: begin
					put_event(EV_NUMBYTE, "/", ERR_NONE);
					put_event(EV_NUMEND, 8'h00, ERR_NONE);
				end
				LX_NUMBER:  put_event(EV_NUMEND, 8'h00, ERR_NONE);
				LX_LITERAL: put_event(EV_ERROR, 8'h00, ERR_LITERAL);
				LX_STRING, LX_UNICODE: put_event(EV_ERROR, 8'h00, ERR_UNTERM);
				LX_ESCAPE:  put_event(EV_ERROR, 8'h00, ERR_ESCAPE);
				default: ;
			endcase
		end
		put_event(EV_EOS, 8'h00, ERR_NONE);
		lex_reset();
	endfunction

	// Fills burst with the events that one byte transaction causes.
	function automatic void predict_tokens(logic [7:0] c, logic eoi);
		burst.delete();
		if (eoi) begin
			lex_end();
		end else if (!halted) begin
			case (lx_mode)
				LX_SLASH: begin
					if (c == "/") begin
						lx_mode = LX_COMMENT;
					end else begin
						// A lone slash is the first byte of a number.
						put_event(EV_NUMBYTE, "/", ERR_NONE);
						lx_mode   = LX_NUMBER;
						num_phase = NP_START;
						lex_number(c);
					end
				end
				LX_COMMENT: if (c == "\n") lx_mode = LX_IDLE;
				LX_LITERAL: lex_literal(c);
				LX_STRING: begin
					if (c == "\"") begin
						put_event(EV_STREND, 8'h00, ERR_NONE);
						lx_mode = LX_IDLE;
					end else if (c == "\\") begin
						lx_mode = LX_ESCAPE;
					end else begin
						put_event(EV_STRBYTE, c, ERR_NONE);
					end
				end
				LX_ESCAPE:  lex_escape(c);
				LX_UNICODE: lex_unicode(c);
				LX_NUMBER:  lex_number(c);
				default:    lex_idle(c);
			endcase
		end
		if (burst.size() > 0)
			burst[burst.size()-1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Random stream builder. Most of the stream is well-formed JSON tokens
	// with random content so that strings, escapes, code points and numbers
	// are all exercised; a minority is noise, broken tokens and early ends.
	// ------------------------------------------------------------------------
	function automatic void add(logic [7:0] d);
		plan.push_back(raw(d, 1'b0));
	endfunction

	// End of input carries a random data byte, which the block must ignore.
	function automatic void add_eoi();
		plan.push_back(raw(8'($urandom_range(255)), 1'b1));
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(9));
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10) return 8'("0" + n);
		if ($urandom_range(1) == 0) return 8'("a" + n - 10);
		return 8'("A" + n - 10);
	endfunction

	function automatic logic [7:0] pick_struct();
		case ($urandom_range(5))
			0:       return "{";
			1:       return "}";
			2:       return "[";
			3:       return "]";
			4:       return ",";
			default: return ":";
		endcase
	endfunction

	function automatic logic [7:0] pick_space();
		int n;
		n = $urandom_range(6);
		return (n == 6) ? " " : 8'(9 + n);
	endfunction

	function automatic logic [7:0] pick_escape();
		case ($urandom_range(7))
			0:       return "\"";
			1:       return "/";
			2:       return "\\";
			3:       return "b";
			4:       return "f";
			5:       return "n";
			6:       return "r";
			default: return "t";
		endcase
	endfunction

	function automatic void gen_literal();
		lit_sel_e sel;
		int len;
		int r;
		int cut;
		logic [7:0] d;
		sel = lit_sel_e'($urandom_range(2));
		len = lit_length(sel);
		add(sel == LIT_NULL ? "n" : sel == LIT_TRUE ? "t" : "f");
		r = $urandom_range(99);
		if (r < 8) begin
			// Wrong character somewhere in the literal, then end of input.
			cut = $urandom_range(len - 1);
			for (int p = 0; p < cut; p++) add(lit_char(sel, p));
			do d = rand_byte(); while (d == lit_char(sel, cut));
			add(d);
			add_eoi();
		end else if (r < 12) begin
			// Input ends inside the literal.
			cut = $urandom_range(len - 1);
			for (int p = 0; p < cut; p++) add(lit_char(sel, p));
			add_eoi();
		end else begin
			for (int p = 0; p < len; p++) add(lit_char(sel, p));
		end
	endfunction

	function automatic void gen_unicode();
		logic [15:0] cp;
		case ($urandom_range(2))
			0:       cp = 16'($urandom_range(16'h007F));
			1:       cp = 16'($urandom_range(16'h07FF, 16'h0080));
			default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
		endcase
		add("\\");
		add("u");
		for (int i = 3; i >= 0; i--) add(hex_char(cp[4*i +: 4]));
	endfunction

	function automatic void gen_string();
		int r;
		int n;
		logic [7:0] d;
		add("\"");
		n = $urandom_range(6);
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 55) begin
				do d = rand_byte(); while (d == "\"" || d == "\\");
				add(d);
			end else if (r < 80) begin
				add("\\");
				add(pick_escape());
			end else begin
				gen_unicode();
			end
		end
		r = $urandom_range(99);
		if (r < 3) begin
			// Escape with no meaning.
			add("\\");
			do d = rand_byte();
			while (d inside {"\"", "/", "\\", "b", "f", "n", "r", "t", "u"});
			add(d);
			add_eoi();
		end else if (r < 6) begin
			// Code point cut short by a byte that is not a hex digit.
			add("\\");
			add("u");
			repeat ($urandom_range(3)) add(hex_char(4'($urandom_range(15))));
			do d = rand_byte(); while (hex_nibble(d) >= 0);
			add(d);
			add_eoi();
		end else if (r < 10) begin
			// Input ends inside the string, an escape or a code point.
			case ($urandom_range(2))
				0: ;
				1: add("\\");
				default: begin
					add("\\");
					add("u");
					repeat ($urandom_range(3)) add(hex_char(4'($urandom_range(15))));
				end
			endcase
			add_eoi();
		end else begin
			add("\"");
		end
	endfunction

	function automatic void gen_number();
		int r;
		if ($urandom_range(2) == 0) add("-");
		repeat ($urandom_range(4, 1)) add(rand_digit());
		if ($urandom_range(2) == 0) begin
			add(".");
			repeat ($urandom_range(3, 1)) add(rand_digit());
		end
		if ($urandom_range(2) == 0) begin
			add($urandom_range(1) ? "e" : "E");
			r = $urandom_range(2);
			if (r == 1) add("+");
			else if (r == 2) add("-");
			repeat ($urandom_range(3, 1)) add(rand_digit());
		end
	endfunction

	function automatic void gen_comment();
		logic [7:0] d;
		add("/");
		add("/");
		repeat ($urandom_range(6)) begin
			do d = rand_byte(); while (d == "\n");
			add(d);
		end
		add("\n");
	endfunction

	function automatic void gen_token();
		int r;
		r = $urandom_range(99);
		if (r < 12)      add(pick_struct());
		else if (r < 20) repeat ($urandom_range(3, 1)) add(pick_space());
		else if (r < 30) gen_literal();
		else if (r < 50) gen_string();
		else if (r < 65) gen_number();
		else if (r < 70) gen_comment();
		else if (r < 74) add("/");
		else if (r < 82) add(rand_byte());
		else if (r < 86) add_eoi();
		else             add(pick_struct());
	endfunction

	// ------------------------------------------------------------------------
	// Byte sender. Valid is driven at the rising edge and ready is looked at
	// on the falling edge, so the acceptance decision never races the block.
	// ------------------------------------------------------------------------
	task automatic send_item(input stim_t s);
		bit took;
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		offered.push_back(s);
		byte_ch.valid        <= 1'b1;
		byte_ch.data_byte    <= s.data;
		byte_ch.end_of_input <= s.eoi;
		do begin
			@(negedge clk);
			took = byte_ch.ready;
			@(posedge clk);
		end while (!took);
	endtask

	// Returns at a falling edge once every accepted byte has been matched
	// and every event it caused has been taken.
	task automatic wait_drained();
		do @(negedge clk); while (offered.size() != 0 || tok_expect.size() != 0);
	endtask

	task automatic note_mismatch(input string what, input res_t want, input res_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH (%s): expected kind=%0d value=%02h err=%0d last=%0b, %s",
				what, want.kind, want.value, want.err, want.last,
				$sformatf("got kind=%0d value=%02h err=%0d last=%0b",
					got.kind, got.value, got.err, got.last));
	endtask

	// ------------------------------------------------------------------------
	// Event receiver. Ready is random at the phase's rate, except during a
	// hold-off: when the stimulus toggles hold_go, ready stays low until
	// hold_cnt, loaded from hold_len, has run down; the sender keeps offering
	// bytes, which fills the block's event queue and makes it refuse input.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_ch.ready <= 1'b0;
			hold_seen      <= 1'b0;
			hold_cnt       <= 0;
		end else if (hold_go != hold_seen) begin
			hold_seen      <= hold_go;
			hold_cnt       <= hold_len;
			token_ch.ready <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt       <= hold_cnt - 1;
			token_ch.ready <= 1'b0;
		end else begin
			token_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Handshakes are decided here, at the falling edge after the last change.
	always @(negedge clk) begin
		byte_fire     = arst_n && byte_ch.valid && byte_ch.ready;
		tok_fire      = arst_n && token_ch.valid && token_ch.ready;
		tok_got.kind  = token_ch.event_kind;
		tok_got.value = token_ch.value_byte;
		tok_got.err   = token_ch.error_code;
		tok_got.last  = token_ch.last_of_run;
	end

	// ------------------------------------------------------------------------
	// Scoreboard. On each accepted byte the bench lexer is stepped and its
	// events, or the table's typed ones, join the queue of owed events. Each
	// event taken from the block is checked against the oldest owed one.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		stim_t s;
		res_t  want;
		if (byte_fire) begin
			s = offered.pop_front();
			predict_tokens(s.data, s.eoi);
			n_bytes++;
			if (burst.size() == MAX_RES) n_bursts3++;
			if (s.typed) begin
				for (int i = 0; i < int'(s.cnt); i++) tok_expect.push_back(s.rs[i]);
			end else begin
				foreach (burst[i]) tok_expect.push_back(burst[i]);
			end
		end
		if (tok_fire) begin
			n_events++;
			if (tok_got.kind == EV_ERROR) n_errs++;
			if (tok_got.kind == EV_EOS) n_eos++;
			if (tok_expect.size() == 0) begin
				note_mismatch("event with nothing owed", NO_RES, tok_got);
			end else begin
				want = tok_expect.pop_front();
				if (want.kind !== tok_got.kind || want.value !== tok_got.value ||
						want.err !== tok_got.err || want.last !== tok_got.last)
					note_mismatch("event fields", want, tok_got);
			end
		end
	end

	// Watchdog: a long stretch with no transaction on either side means the
	// block has hung.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (byte_fire || tok_fire) quiet = 0;
			else quiet++;
		end
		$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("json_byte_tokenizer verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus.
	// ------------------------------------------------------------------------
	initial begin : stimulus
		stim_t dir_rows [DIR_ROWS];

		arst_n               = 1'b0;
		byte_ch.valid        = 1'b0;
		byte_ch.data_byte    = 8'h00;
		byte_ch.end_of_input = 1'b0;
		lex_reset();

		// Directed table. Structural bytes, a completed literal, end of
		// input behind a pending number, inside a string and after an error
		// are typed in; the rest is left to the bench lexer. The rows also
		// cover a lone slash giving three events, a full three-byte code
		// point, and the byte extremes inside a string and a literal.
		dir_rows[0]  = mk("{", 1'b0, 1'b1, 2'd1, tk(EV_LBRACE, 8'h00, ERR_NONE, 1'b1),
			NO_RES, NO_RES);
		dir_rows[1]  = mk("}", 1'b0, 1'b1, 2'd1, tk(EV_RBRACE, 8'h00, ERR_NONE, 1'b1),
			NO_RES, NO_RES);
		dir_rows[2]  = mk("[", 1'b0, 1'b1, 2'd1, tk(EV_LBRACK, 8'h00, ERR_NONE, 1'b1),
			NO_RES, NO_RES);
		dir_rows[3]  = mk("]", 1'b0, 1'b1, 2'd1, tk(EV_RBRACK, 8'h00, ERR_NONE, 1'b1),
			NO_RES, NO_RES);
		dir_rows[4]  = mk(",", 1'b0, 1'b1, 2'd1, tk(EV_COMMA, 8'h00, ERR_NONE, 1'b1),
			NO_RES, NO_RES);
		dir_rows[5]  = mk(":", 1'b0, 1'b1, 2'd1, tk(EV_COLON, 8'h00, ERR_NONE, 1'b1),
			NO_RES, NO_RES);
		dir_rows[6]  = raw("n", 1'b0);
		dir_rows[7]  = raw("u", 1'b0);
		dir_rows[8]  = raw("l", 1'b0);
		dir_rows[9]  = mk("l", 1'b0, 1'b1, 2'd1, tk(EV_NULL, 8'h00, ERR_NONE, 1'b1),
			NO_RES, NO_RES);
		dir_rows[10] = raw("/", 1'b0);
		dir_rows[11] = raw("a", 1'b0);
		dir_rows[12] = mk(8'h00, 1'b1, 1'b1, 2'd2, tk(EV_NUMEND, 8'h00, ERR_NONE, 1'b0),
			tk(EV_EOS, 8'h00, ERR_NONE, 1'b1), NO_RES);
		dir_rows[13] = raw("\"", 1'b0);
		dir_rows[14] = raw("\\", 1'b0);
		dir_rows[15] = raw("u", 1'b0);
		dir_rows[16] = raw("F", 1'b0);
		dir_rows[17] = raw("F", 1'b0);
		dir_rows[18] = raw("F", 1'b0);
		dir_rows[19] = raw("F", 1'b0);
		dir_rows[20] = raw(8'hFF, 1'b0);
		dir_rows[21] = mk(8'hFF, 1'b1, 1'b1, 2'd2, tk(EV_ERROR, 8'h00, ERR_UNTERM, 1'b0),
			tk(EV_EOS, 8'h00, ERR_NONE, 1'b1), NO_RES);
		dir_rows[22] = raw("f", 1'b0);
		dir_rows[23] = mk(8'h00, 1'b0, 1'b1, 2'd1, tk(EV_ERROR, 8'h00, ERR_LITERAL, 1'b1),
			NO_RES, NO_RES);
		dir_rows[24] = raw("\"", 1'b0);
		dir_rows[25] = mk(8'h00, 1'b1, 1'b1, 2'd1, tk(EV_EOS, 8'h00, ERR_NONE, 1'b1),
			NO_RES, NO_RES);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_item(dir_rows[i]);
		byte_ch.valid <= 1'b0;
		wait_drained();

		// Three random phases: receiver idles more than sender, then the
		// other way round, then back to back on both sides. Every phase
		// closes with end of input so the next one starts from idle, and the
		// sender pauses between phases until every owed event has come.
		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 56 : 0;
			snk_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 34 : 0;
			plan.delete();
			while (plan.size() < PHASE_ITEMS) gen_token();
			add_eoi();
			if (ph == 2) begin
				// Long receiver stall while bytes keep coming at full rate.
				hold_len = HOLD_CYCLES;
				hold_go  = ~hold_go;
			end
			@(posedge clk);
			foreach (plan[i]) send_item(plan[i]);
			byte_ch.valid <= 1'b0;
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tok_expect.size() != 0) begin
			mismatches += tok_expect.size();
			$display("%0d owed events never arrived", tok_expect.size());
		end

		$display("Covered %0d input bytes over three handshake mixes and a %0d-cycle stall;",
			n_bytes, HOLD_CYCLES);
		$display("checked %0d events: %0d errors, %0d end-of-stream, %0d three-event bursts.",
			n_events, n_errs, n_eos, n_bursts3);
		if (mismatches == 0) begin
			$display("json_byte_tokenizer verification clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("json_byte_tokenizer verification failed");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/jbt_pkg.sv
hw/rtl/jbt_if.sv
hw/rtl/jbt_lexer.sv
hw/rtl/jbt_queue.sv
hw/rtl/json_byte_tokenizer.sv
tb/json_byte_tokenizer_tb.sv
